// ===== sv/at_response_frame_parser_top_macros.svh =====
// Assertion macros shared by the parser RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef AT_RESPONSE_FRAME_PARSER_TOP_MACROS_SVH
`define AT_RESPONSE_FRAME_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge outside reset.
`define ATRP_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// A condition that, once seen, implies another in the next cycle.
`define ATRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ATRP_ASSERT(label, clk, rst_n, expr, msg)
`define ATRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/atrp_pkg.sv =====
package atrp_pkg;

    // Frame and channel limits.
    localparam int PAYLOAD_MAX = 1024;
    localparam int CHANNELS    = 4;
    localparam int LEN_W       = 11;
    localparam int CHAN_W      = 4;
    localparam int MASK_W      = 4;
    localparam logic [LEN_W-1:0]  LEN_SAT  = 11'd2047;
    localparam logic [CHAN_W-1:0] CHAN_SAT = 4'd15;

    // Bytes with a meaning in line mode.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Keywords, first character at index 0.
    typedef logic [0:6][7:0] t_kw;
    localparam t_kw KW_IPD     = {"+IPD", 24'h0};
    localparam t_kw KW_CONNECT = "CONNECT";
    localparam t_kw KW_CLOSED  = {"CLOSED", 8'h0};
    localparam logic [2:0] KW_IPD_LEN     = 3'd4;
    localparam logic [2:0] KW_CONNECT_LEN = 3'd7;
    localparam logic [2:0] KW_CLOSED_LEN  = 3'd6;

    // Bit positions in the keyword-found mask.
    localparam int KF_IPD     = 0;
    localparam int KF_CONNECT = 1;
    localparam int KF_CLOSED  = 2;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_OPEN     = 2'd1,
        EV_CLOSE    = 2'd2,
        EV_ANNOUNCE = 2'd3
    } t_event_kind;

    // Position in the +IPD header.
    typedef enum logic [1:0] {
        FI_NONE  = 2'd0,
        FI_AFTER = 2'd1,
        FI_CHAN  = 2'd2,
        FI_LEN   = 2'd3
    } t_field;

    typedef struct packed {
        t_event_kind       event_kind;
        logic [CHAN_W-1:0] link_channel;
        logic [7:0]        data_byte;
        logic              last_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [MASK_W-1:0] open_mask;
    } t_result;

    typedef struct packed {
        logic              payload_mode;
        logic [MASK_W-1:0] open_flags;
    } t_core_status;

    // Longest keyword prefix that ends the text made of the matched prefix
    // followed by the new byte.
    function automatic logic [2:0] advance_match(input t_kw kw, input logic [2:0] klen,
                                                 input logic [2:0] state,
                                                 input logic [7:0] c);
        logic [7:0] text [0:7];
        logic [2:0] st;
        logic [3:0] n;
        logic [2:0] best;
        logic       ok;
        st = (state > klen) ? klen : state;
        if (st > 3'd6) begin
            st = 3'd6;
        end
        for (int i = 0; i < 7; i++) begin
            text[i] = kw[i];
        end
        text[7] = 8'h00;
        text[st] = c;
        n = {1'b0, st} + 4'd1;
        best = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if ((4'(k) <= n) && (3'(k) <= klen)) begin
                ok = 1'b1;
                for (int i = 0; i < 7; i++) begin
                    if (i < k) begin
                        if (text[3'(int'(n) - k + i)] != kw[i]) begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok) begin
                    best = 3'(k);
                end
            end
        end
        return best;
    endfunction

endpackage

// ===== sv/atrp_if.sv =====
interface atrp_in_if;
    import atrp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface atrp_out_if;
    import atrp_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [CHAN_W-1:0] link_channel;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  frame_length;
    logic [MASK_W-1:0] open_mask;
    modport source (output valid, output event_kind, output link_channel,
                    output data_byte, output last_byte, output frame_length,
                    output open_mask, input ready);
    modport sink (input valid, input event_kind, input link_channel,
                  input data_byte, input last_byte, input frame_length,
                  input open_mask, output ready);
endinterface

// ===== sv/at_response_frame_parser_top.sv =====
// AT response parser for the byte stream received from a modem.
// Input channel i_in carries one received byte per word (rx_byte). Output
// channel o_out carries one event word: a payload byte with its last mark,
// a channel opened or closed, or a payload announcement with its length,
// always together with the current open mask of channels 0 to 3.
// Line bytes that do not complete an event produce no output word.
// Each event word is registered in the output buffer when its byte is accepted.
// Throughput: one byte per cycle while i_in.ready is high; the matchers and
// field accumulators are updated by a single pass of logic between the state
// registers and a two-word output buffer.
// When the receiver stalls, the output buffer absorbs up to two event words
// while bytes keep being accepted; i_in.ready drops only when both buffer
// words are occupied, and rises again as soon as one word is taken.
// Reset (i_rst_n low at a clock edge) returns the parser to line mode,
// clears every matcher, empties the output buffer and marks all channels
// as closed.
`include "at_response_frame_parser_top_macros.svh"

module at_response_frame_parser_top (
    input logic        i_clk,
    input logic        i_rst_n,
    atrp_in_if.sink    i_in,
    atrp_out_if.source o_out
);
    import atrp_pkg::*;

    // Core handshake and result.
    logic         w_accept;
    logic         w_res_valid;
    t_result      w_res;
    t_core_status w_status;

    // Two-word output buffer, read at its head pointer.
    t_result    r_buf [0:1];
    logic [1:0] r_count, n_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic       w_push;
    logic       w_pop;

    assign i_in.ready = (r_count != 2'd2);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_push     = w_accept && w_res_valid;
    assign w_pop      = o_out.valid && o_out.ready;

    atrp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_in.rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_status    (w_status)
    );

    // The count moves by the difference of writes and reads this cycle.
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Event data needs no reset; the count says which words are meaningful.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_res;
        end
    end

    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.event_kind   = r_buf[r_rd_ptr].event_kind;
    assign o_out.link_channel = r_buf[r_rd_ptr].link_channel;
    assign o_out.data_byte    = r_buf[r_rd_ptr].data_byte;
    assign o_out.last_byte    = r_buf[r_rd_ptr].last_byte;
    assign o_out.frame_length = r_buf[r_rd_ptr].frame_length;
    assign o_out.open_mask    = r_buf[r_rd_ptr].open_mask;

    // A payload word can only come from a parser that is in payload mode.
    `ATRP_ASSERT(a_payload_in_mode, i_clk, i_rst_n, !(w_push && (w_res.event_kind == EV_PAYLOAD)) || w_status.payload_mode, "payload word produced outside payload mode")
    // The last byte of a frame returns the parser to line mode.
    `ATRP_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, w_push && (w_res.event_kind == EV_PAYLOAD) && w_res.last_byte, !w_status.payload_mode, "parser stayed in payload mode after last byte")
    // A read with no write drops the buffer fill by exactly one word.
    `ATRP_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push, r_count == ($past(r_count) - 2'd1), "output buffer count out of step with reads")

endmodule

// ===== sv/atrp_core.sv =====
module atrp_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_res_valid,
    output atrp_pkg::t_result      o_res,
    output atrp_pkg::t_core_status o_status
);
    import atrp_pkg::*;

    logic                r_payload_mode, n_payload_mode;
    logic [2:0]          r_ipd_match, n_ipd_match;
    logic [2:0]          r_connect_match, n_connect_match;
    logic [2:0]          r_closed_match, n_closed_match;
    logic [2:0]          r_keyword_found, n_keyword_found;
    logic [CHANNELS-1:0] r_digits_seen, n_digits_seen;
    t_field              r_field_index, n_field_index;
    logic [CHAN_W-1:0]   r_chan_accum, n_chan_accum;
    logic [LEN_W-1:0]    r_length_accum, n_length_accum;
    logic [LEN_W-1:0]    r_bytes_needed, n_bytes_needed;
    logic [LEN_W-1:0]    r_bytes_taken, n_bytes_taken;
    logic [MASK_W-1:0]   r_open_flags, n_open_flags;

    logic              clear_line;
    logic              last;
    logic [LEN_W-1:0]  taken_inc;
    logic [LEN_W-1:0]  len_sel;
    logic [CHAN_W-1:0] chan_sel;
    logic              digit_found;
    logic [CHAN_W-1:0] low_digit;
    logic [MASK_W-1:0] low_bit;
    logic              is_digit;
    logic [3:0]        digit_val;
    logic [7:0]        chan_prod;
    logic [14:0]       len_prod;

    assign is_digit  = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit_val = 4'(i_rx_byte - CH_ZERO);
    assign chan_prod = {4'd0, r_chan_accum} * 8'd10 + {4'd0, digit_val};
    assign len_prod  = {4'd0, r_length_accum} * 15'd10 + {11'd0, digit_val};
    assign taken_inc = r_bytes_taken + LEN_W'(1);
    assign last      = taken_inc >= r_bytes_needed;

    // Lowest channel digit seen in the line.
    always_comb begin
        digit_found = 1'b0;
        low_digit   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (r_digits_seen[i]) begin
                digit_found = 1'b1;
                low_digit   = CHAN_W'(i);
            end
        end
        low_bit = MASK_W'(1) << low_digit[1:0];
    end

    // The +IPD header fields as they stand at the terminator.
    always_comb begin
        len_sel  = (r_field_index == FI_LEN) ? r_length_accum : '0;
        chan_sel = ((r_field_index == FI_CHAN) || (r_field_index == FI_LEN))
                   ? r_chan_accum : '0;
        if (len_sel > LEN_W'(PAYLOAD_MAX)) begin
            len_sel = LEN_W'(PAYLOAD_MAX - 1);
        end
    end

    always_comb begin
        n_payload_mode  = r_payload_mode;
        n_ipd_match     = r_ipd_match;
        n_connect_match = r_connect_match;
        n_closed_match  = r_closed_match;
        n_keyword_found = r_keyword_found;
        n_digits_seen   = r_digits_seen;
        n_field_index   = r_field_index;
        n_chan_accum    = r_chan_accum;
        n_length_accum  = r_length_accum;
        n_bytes_needed  = r_bytes_needed;
        n_bytes_taken   = taken_inc;
        n_open_flags    = r_open_flags;
        clear_line      = 1'b0;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (r_payload_mode) begin
            o_res_valid         = 1'b1;
            o_res.event_kind    = EV_PAYLOAD;
            o_res.link_channel  = r_chan_accum;
            o_res.data_byte     = i_rx_byte;
            o_res.last_byte     = last;
            o_res.frame_length  = r_bytes_needed;
            if (last) begin
                n_payload_mode = 1'b0;
                n_chan_accum   = '0;
                clear_line     = 1'b1;
            end
        end else begin
            n_bytes_taken = r_bytes_taken;
            if ((i_rx_byte == CH_LF) || (i_rx_byte == CH_COLON)) begin
                clear_line = 1'b1;
                if (r_keyword_found[KF_IPD]) begin
                    n_bytes_needed     = len_sel;
                    n_bytes_taken      = '0;
                    n_payload_mode     = (len_sel != '0);
                    n_chan_accum       = (len_sel != '0) ? chan_sel : '0;
                    o_res_valid        = 1'b1;
                    o_res.event_kind   = EV_ANNOUNCE;
                    o_res.link_channel = chan_sel;
                    o_res.frame_length = len_sel;
                end else begin
                    n_chan_accum = '0;
                    if ((r_keyword_found[KF_CONNECT] || r_keyword_found[KF_CLOSED])
                        && digit_found) begin
                        o_res_valid        = 1'b1;
                        o_res.link_channel = low_digit;
                        if (r_keyword_found[KF_CONNECT]) begin
                            n_open_flags     = r_open_flags | low_bit;
                            o_res.event_kind = EV_OPEN;
                        end else begin
                            n_open_flags     = r_open_flags & ~low_bit;
                            o_res.event_kind = EV_CLOSE;
                        end
                    end
                end
            end else begin
                n_ipd_match     = advance_match(KW_IPD, KW_IPD_LEN, r_ipd_match, i_rx_byte);
                n_connect_match = advance_match(KW_CONNECT, KW_CONNECT_LEN, r_connect_match,
                                                i_rx_byte);
                n_closed_match  = advance_match(KW_CLOSED, KW_CLOSED_LEN, r_closed_match,
                                                i_rx_byte);
                if (n_connect_match == KW_CONNECT_LEN) begin
                    n_keyword_found[KF_CONNECT] = 1'b1;
                end
                if (n_closed_match == KW_CLOSED_LEN) begin
                    n_keyword_found[KF_CLOSED] = 1'b1;
                end

                if (is_digit) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (digit_val == 4'(i)) begin
                            n_digits_seen[i] = 1'b1;
                        end
                    end
                    if (r_field_index == FI_CHAN) begin
                        n_chan_accum = (chan_prod > {4'd0, CHAN_SAT}) ? CHAN_SAT
                                       : chan_prod[CHAN_W-1:0];
                    end else if (r_field_index == FI_LEN) begin
                        n_length_accum = (len_prod > {4'd0, LEN_SAT}) ? LEN_SAT
                                         : len_prod[LEN_W-1:0];
                    end
                end else if (i_rx_byte == CH_COMMA) begin
                    if (r_field_index == FI_AFTER) begin
                        n_field_index = FI_CHAN;
                        n_chan_accum  = '0;
                    end else if (r_field_index == FI_CHAN) begin
                        n_field_index  = FI_LEN;
                        n_length_accum = '0;
                    end
                end

                // A new +IPD restarts the header fields.
                if (n_ipd_match == KW_IPD_LEN) begin
                    n_keyword_found[KF_IPD] = 1'b1;
                    n_field_index           = FI_AFTER;
                    n_chan_accum            = '0;
                    n_length_accum          = '0;
                end
            end
        end

        if (clear_line) begin
            n_ipd_match     = '0;
            n_connect_match = '0;
            n_closed_match  = '0;
            n_keyword_found = '0;
            n_digits_seen   = '0;
            n_field_index   = FI_NONE;
            n_length_accum  = '0;
        end

        o_res.open_mask = n_open_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_mode  <= 1'b0;
            r_ipd_match     <= '0;
            r_connect_match <= '0;
            r_closed_match  <= '0;
            r_keyword_found <= '0;
            r_digits_seen   <= '0;
            r_field_index   <= FI_NONE;
            r_chan_accum    <= '0;
            r_length_accum  <= '0;
            r_bytes_needed  <= '0;
            r_bytes_taken   <= '0;
            r_open_flags    <= '0;
        end else if (i_accept) begin
            r_payload_mode  <= n_payload_mode;
            r_ipd_match     <= n_ipd_match;
            r_connect_match <= n_connect_match;
            r_closed_match  <= n_closed_match;
            r_keyword_found <= n_keyword_found;
            r_digits_seen   <= n_digits_seen;
            r_field_index   <= n_field_index;
            r_chan_accum    <= n_chan_accum;
            r_length_accum  <= n_length_accum;
            r_bytes_needed  <= n_bytes_needed;
            r_bytes_taken   <= n_bytes_taken;
            r_open_flags    <= n_open_flags;
        end
    end

    assign o_status.payload_mode = r_payload_mode;
    assign o_status.open_flags   = r_open_flags;

endmodule

// ===== dv/tb_at_response_frame_parser_top.sv =====
module tb_at_response_frame_parser_top;
    import atrp_pkg::*;

    // Longest run of cycles with no word moving on either channel before the
    // run is declared hung. The longest legal quiet stretch is the receiver
    // hold-off below plus a few random gaps, so this leaves ample margin.
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_OFF    = 300;
    localparam int unsigned RANDOM_BYTES = 620;
    localparam int unsigned CLAMP_BYTES  = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    atrp_in_if  rx_bus ();
    atrp_out_if ev_bus ();

    at_response_frame_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_bus),
        .o_out   (ev_bus)
    );

    // ------------------------------------------------------------------
    // Parser mirror. These variables track the parser state exactly as the
    // hardware should, and are updated once for every accepted byte.
    // ------------------------------------------------------------------
    logic        in_payload  = 1'b0;
    logic [2:0]  ipd_len_m   = '0;   // matched prefix length of "+IPD"
    logic [2:0]  conn_len_m  = '0;   // matched prefix length of "CONNECT"
    logic [2:0]  clsd_len_m  = '0;   // matched prefix length of "CLOSED"
    logic [2:0]  kw_seen     = '0;   // keywords completed in this line
    logic [3:0]  digit_mask  = '0;   // channel digits seen in this line
    t_field      hdr_field   = FI_NONE;
    logic [3:0]  chan_acc    = '0;
    logic [10:0] len_acc     = '0;
    logic [10:0] frame_need  = '0;
    logic [10:0] frame_taken = '0;
    logic [3:0]  open_flags  = '0;

    // Event words predicted but not yet seen on the output channel.
    t_result pending_events [$];

    int unsigned rx_count     = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;

    // Idle controls shared between the test tasks and the channel drivers.
    bit          in_idle_on   = 1'b1;
    bit          out_idle_on  = 1'b1;
    int unsigned hold_cycles  = 0;

    // Length of the next idle gap: mostly none, sometimes a few cycles, and
    // now and then a long one.
    function automatic int unsigned idle_len(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Keyword matcher: the longest prefix of the keyword that ends the text
    // formed by the prefix matched so far followed by the new byte.
    function automatic logic [2:0] prefix_after(input logic [2:0] matched, input string kw,
                                                input logic [7:0] c);
        byte unsigned txt [0:7];
        int           klen;
        int           s;
        int           n;
        bit           ok;
        klen = kw.len();
        s = (matched > klen) ? klen : matched;
        if (s > 6) begin
            s = 6;
        end
        for (int i = 0; i < s; i++) begin
            txt[i] = kw[i];
        end
        txt[s] = c;
        n = s + 1;
        for (int k = (n < klen) ? n : klen; k > 0; k--) begin
            ok = 1'b1;
            for (int i = 0; i < k; i++) begin
                if (txt[n - k + i] != kw[i]) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                return 3'(k);
            end
        end
        return 3'd0;
    endfunction

    // Everything that belongs to one line is forgotten at its terminator.
    function automatic void clear_line();
        ipd_len_m  = '0;
        conn_len_m = '0;
        clsd_len_m = '0;
        kw_seen    = '0;
        digit_mask = '0;
        hdr_field  = FI_NONE;
        len_acc    = '0;
    endfunction

    // Advances the mirror by one accepted byte and queues the event word
    // that the byte should produce, if any.
    function automatic void parse_byte(input logic [7:0] b);
        t_result ev;
        int      d;
        int      acc;
        logic [3:0]  ch;
        logic [10:0] len;
        ev = '0;

        // Payload mode: every byte goes straight out, terminators included.
        if (in_payload) begin
            frame_taken = frame_taken + 11'd1;
            ev.event_kind   = EV_PAYLOAD;
            ev.link_channel = chan_acc;
            ev.data_byte    = b;
            ev.last_byte    = (frame_taken >= frame_need);
            ev.frame_length = frame_need;
            ev.open_mask    = open_flags;
            if (ev.last_byte) begin
                in_payload = 1'b0;
                chan_acc   = '0;
                clear_line();
            end
            pending_events.push_back(ev);
            return;
        end

        if (b == CH_LF || b == CH_COLON) begin
            if (kw_seen[KF_IPD]) begin
                // +IPD wins over the status keywords. Missing fields are 0.
                len = (hdr_field == FI_LEN) ? len_acc : 11'd0;
                ch  = (hdr_field >= FI_CHAN) ? chan_acc : 4'd0;
                if (len > PAYLOAD_MAX) begin
                    len = 11'(PAYLOAD_MAX - 1);
                end
                frame_need  = len;
                frame_taken = '0;
                in_payload  = (len != 11'd0);
                chan_acc    = in_payload ? ch : 4'd0;
                ev.event_kind   = EV_ANNOUNCE;
                ev.link_channel = ch;
                ev.frame_length = len;
                ev.open_mask    = open_flags;
                pending_events.push_back(ev);
            end else if (kw_seen[KF_CONNECT] || kw_seen[KF_CLOSED]) begin
                // The lowest channel digit of the line is the one acted on;
                // with no digit the line is simply dropped.
                d = -1;
                for (int i = CHANNELS - 1; i >= 0; i--) begin
                    if (digit_mask[i]) begin
                        d = i;
                    end
                end
                if (d >= 0) begin
                    if (kw_seen[KF_CONNECT]) begin
                        open_flags[d] = 1'b1;
                        ev.event_kind = EV_OPEN;
                    end else begin
                        open_flags[d] = 1'b0;
                        ev.event_kind = EV_CLOSE;
                    end
                    ev.link_channel = 4'(d);
                    ev.open_mask    = open_flags;
                    pending_events.push_back(ev);
                end
                chan_acc = '0;
            end else begin
                chan_acc = '0;
            end
            clear_line();
            return;
        end

        ipd_len_m  = prefix_after(ipd_len_m, "+IPD", b);
        conn_len_m = prefix_after(conn_len_m, "CONNECT", b);
        clsd_len_m = prefix_after(clsd_len_m, "CLOSED", b);
        if (conn_len_m == KW_CONNECT_LEN) begin
            kw_seen[KF_CONNECT] = 1'b1;
        end
        if (clsd_len_m == KW_CLOSED_LEN) begin
            kw_seen[KF_CLOSED] = 1'b1;
        end

        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = int'(b - CH_ZERO);
            if (d < CHANNELS) begin
                digit_mask[d] = 1'b1;
            end
            if (hdr_field == FI_CHAN) begin
                acc = int'(chan_acc) * 10 + d;
                chan_acc = (acc > int'(CHAN_SAT)) ? CHAN_SAT : 4'(acc);
            end else if (hdr_field == FI_LEN) begin
                acc = int'(len_acc) * 10 + d;
                len_acc = (acc > int'(LEN_SAT)) ? LEN_SAT : 11'(acc);
            end
        end else if (b == CH_COMMA) begin
            if (hdr_field == FI_AFTER) begin
                hdr_field = FI_CHAN;
                chan_acc  = '0;
            end else if (hdr_field == FI_CHAN) begin
                hdr_field = FI_LEN;
                len_acc   = '0;
            end
        end

        // A fresh +IPD restarts the header, even in the middle of one.
        if (ipd_len_m == KW_IPD_LEN) begin
            kw_seen[KF_IPD] = 1'b1;
            hdr_field = FI_AFTER;
            chan_acc  = '0;
            len_acc   = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side. Each call is entered at a falling edge, offers one byte,
    // waits for the handshake and returns at the following falling edge
    // with valid still high, so back-to-back bytes never toggle valid.
    // ------------------------------------------------------------------
    task automatic send_rx(input logic [7:0] b);
        int unsigned gap;
        gap = idle_len(in_idle_on);
        if (gap != 0) begin
            rx_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (rx_bus.ready !== 1'b1);
        parse_byte(b);
        rx_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_rx(s[i]);
        end
    endtask

    task automatic send_term();
        if ($urandom_range(0, 1) != 0) begin
            send_rx(CH_LF);
        end else begin
            send_rx(CH_COLON);
        end
    endtask

    // Random payload until the announced frame is complete.
    task automatic finish_frame();
        while (in_payload) begin
            send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    // Line noise, weighted toward the bytes that the matchers care about.
    task automatic send_junk(input int unsigned n);
        string alphabet;
        alphabet = "+IPDCONECTLS0123456789, ";
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                send_rx(alphabet[$urandom_range(0, alphabet.len() - 1)]);
            end else begin
                send_rx(8'($urandom_range(0, 255)));
            end
        end
    endtask

    function automatic string digit_run(input int unsigned n);
        string s;
        s = "";
        for (int unsigned i = 0; i < n; i++) begin
            s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Output side. The receiver mostly takes every word, stalls at random,
    // and honors a hold-off request counted down here, one cycle per edge.
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        stall = 0;
        ev_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                ev_bus.ready <= 1'b0;
                hold_cycles--;
            end else if (stall != 0) begin
                ev_bus.ready <= 1'b0;
                stall--;
            end else begin
                ev_bus.ready <= 1'b1;
                stall = idle_len(out_idle_on);
            end
        end
    end

    function automatic void check_field(input string name, input logic [10:0] want,
                                        input logic [10:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Every accepted event word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && ev_bus.valid === 1'b1 && ev_bus.ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                $error("event word with nothing expected: kind %0d channel %0d data %0d",
                       ev_bus.event_kind, ev_bus.link_channel, ev_bus.data_byte);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", 11'(want.event_kind), 11'(ev_bus.event_kind));
                check_field("link_channel", 11'(want.link_channel), 11'(ev_bus.link_channel));
                check_field("data_byte", 11'(want.data_byte), 11'(ev_bus.data_byte));
                check_field("last_byte", 11'(want.last_byte), 11'(ev_bus.last_byte));
                check_field("frame_length", want.frame_length, ev_bus.frame_length);
                check_field("open_mask", 11'(want.open_mask), 11'(ev_bus.open_mask));
            end
        end
    end

    // Hang detector: the run ends if no word moves on either channel for
    // too long.
    always @(posedge i_clk) begin
        if ((rx_bus.valid === 1'b1 && rx_bus.ready === 1'b1) ||
            (ev_bus.valid === 1'b1 && ev_bus.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Bytes at both ends of the range and a line with nothing in it.
    task automatic test_line_noise();
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(CH_LF);
        send_rx(CH_COLON);
    endtask

    // Open all four channels so the mask reaches all ones, then close the
    // lowest digit of a line that names two.
    task automatic test_open_close();
        for (int d = 0; d < CHANNELS; d++) begin
            send_text($sformatf("CONNECT %0d", d));
            send_term();
        end
        send_text("CLOSED 2,0");
        send_term();
    endtask

    // Status keywords with no usable channel digit produce nothing.
    task automatic test_missing_digit();
        send_text("CONNECTED");
        send_term();
        send_text("CLOSED 9");
        send_term();
    endtask

    // When a line holds several keywords, +IPD beats CONNECT beats CLOSED.
    task automatic test_keyword_priority();
        send_text("CLOSED 3 CONNECT");
        send_term();
        send_text("CONNECT 1 +IPD,2,1");
        send_term();
        finish_frame();
    endtask

    // A short frame whose payload holds both terminators as plain data.
    task automatic test_basic_frame();
        send_text("+IPD,3,4");
        send_rx(CH_COLON);
        send_rx(CH_LF);
        send_rx(CH_COLON);
        send_rx(8'h00);
        send_rx(8'hFF);
    endtask

    // Header oddities: junk inside fields, extra commas, missing fields
    // (including a zero-length frame) and a second +IPD restarting the header.
    task automatic test_header_fields();
        send_text("+IPD,a1b,2,7");
        send_term();
        finish_frame();
        send_text("+IPD");
        send_term();
        send_text("+IPD,5");
        send_term();
        send_text("+IPD,1,+IPD,2,3");
        send_term();
        finish_frame();
    endtask

    // Channel saturation on a short frame, then a saturated length that gets
    // clamped. The clamped frame is far longer than the rest of the run, so
    // only its first bytes are sent and the run ends inside it. During those
    // bytes the receiver holds off for a long stretch while bytes keep
    // coming, so the output buffer fills and the input stalls.
    task automatic test_saturation_and_clamp();
        send_text("+IPD,123,10");
        send_term();
        finish_frame();
        send_text("+IPD,1,99999");
        send_term();
        in_idle_on  = 1'b0;
        hold_cycles = HOLD_OFF;
        for (int unsigned i = 0; i < CLAMP_BYTES; i++) begin
            send_rx(8'($urandom_range(0, 255)));
        end
        in_idle_on  = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed lines with random content, plus
    // noise, mixed keywords and broken keywords.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned r;
        string       line;
        stop_at = rx_count + n_bytes;
        while (rx_count < stop_at) begin
            // Occasionally switch idling on or off to get gap-free stretches.
            if ($urandom_range(0, 9) == 0) begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 3) == 0) begin
                send_junk($urandom_range(1, 6));
            end
            pick = $urandom_range(0, 99);
            line = "";
            if (pick < 35) begin
                // Frame header; lengths stay small to keep frames short.
                r = $urandom_range(0, 15);
                line = "+IPD";
                if (r != 0) begin
                    line = {line, ",", $sformatf("%0d",
                            (r < 12) ? $urandom_range(0, 3) : $urandom_range(0, 40))};
                    if (r != 1) begin
                        line = {line, ",", $sformatf("%0d",
                                (r < 13) ? $urandom_range(0, 9) : $urandom_range(10, 48))};
                    end
                    if (r == 12) begin
                        line = {line, ",x7"};
                    end
                end
            end else if (pick < 60) begin
                if ($urandom_range(0, 1) != 0) begin
                    line = "CONNECT ";
                end else begin
                    line = "CLOSED ";
                end
                line = {line, digit_run($urandom_range(0, 3))};
            end else if (pick < 75) begin
                // Several keywords in one line, in random order. The +IPD here
                // carries only a channel field, so its frame is always empty.
                for (int i = 0; i < $urandom_range(2, 3); i++) begin
                    case ($urandom_range(0, 3))
                        0: line = {line, " +IPD,", digit_run(1)};
                        1: line = {line, " CONNECT"};
                        2: line = {line, " CLOSED"};
                        default: line = {line, " ", digit_run(2)};
                    endcase
                end
            end else if (pick < 90) begin
                send_junk($urandom_range(0, 12));
            end else begin
                // Truncated, misspelled and overlapping keywords.
                case ($urandom_range(0, 6))
                    0: line = "+IP";
                    1: line = "+I PD,1,2";
                    2: line = "CONNEC";
                    3: line = "CONCONNECT";
                    4: line = "CLOSD";
                    5: line = "CLOCLOSED";
                    default: line = "++IPD,";
                endcase
                line = {line, digit_run($urandom_range(0, 2))};
            end
            send_text(line);
            send_term();
            finish_frame();
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    initial begin
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_line_noise();
        test_open_close();
        test_missing_digit();
        test_keyword_priority();
        test_basic_frame();
        test_header_fields();
        test_random_traffic(RANDOM_BYTES);
        test_saturation_and_clamp();

        // Drain: wait for every predicted word, then a few more cycles to
        // catch any word the parser should not have produced.
        rx_bus.valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
